### hw/rtl/sleep_deadline_wakeup_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Sleep deadline wakeup table - assertion macros
// Shared property wrappers, clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SLEEP_DEADLINE_WAKEUP_TABLE_UNIT_DEFINES_SVH
`define SLEEP_DEADLINE_WAKEUP_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SDWT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SDWT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/sdwt_pkg.sv
// ----------------------------------------------------------------------------
// Sleep deadline wakeup table - package
// Fixed field widths, word layout, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package sdwt_pkg;

    // Input word layout (tdata), lowest bit first
    localparam int PROC_BITS   = 4;
    localparam int FIELD_BITS  = 16;
    localparam int PROC_LSB    = 0;
    localparam int DUR_LSB     = PROC_LSB + PROC_BITS;
    localparam int NOW_LSB     = DUR_LSB + FIELD_BITS;
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 16;
    localparam int CFG_BITS    = 16;
    localparam int MASK_BITS   = 16;

    localparam logic [CFG_BITS-1:0] MAX_TIME_RESET = 16'hFFFF;

    // Operation selector carried in tuser
    localparam logic FUNC_SLEEP = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b000_0001,
        ST_LEFT   = 7'b000_0010,
        ST_CMP    = 7'b000_0100,
        ST_DEAD   = 7'b000_1000,
        ST_WINDOW = 7'b001_0000,
        ST_SWEEP  = 7'b010_0000,
        ST_FINISH = 7'b100_0000
    } state_t;

endpackage

### hw/rtl/sdwt_ram.sv
// ----------------------------------------------------------------------------
// Sleep deadline wakeup table - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sdwt_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/sleep_deadline_wakeup_table_unit.sv
// ----------------------------------------------------------------------------
// Sleep deadline wakeup table
// Per-process sleep deadlines with a wrap-aware wake check over all slots.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Handshake           | Payload
// --------+-----+---------------------+--------------------------------------
// s_      | in  | s_tvalid / s_tready | tuser: func; tdata: proc_index,
//         |     |                     |   duration, now
// m_      | out | m_tvalid / m_tready | tdata: woken_mask
// cfg_    | in  | cfg_valid/cfg_ready | cfg_data: max_time
//
// A sleep request passes LEFT, CMP, DEAD and FINISH before m_tvalid rises;
// a wake check passes WINDOW, SWEEP and FINISH, the sweep reading one
// deadline per cycle from the deadline RAM and testing it against the wake
// window. s_tready returns with the result, so a new word is taken only once
// the previous result sits in the output register.
// Reset (aresetn, synchronous) clears flags and last check time and sets
// max_time to 65535; the deadline RAM is not cleared, since a slot's deadline
// counts only once its flag marks it written. A stalled result waits in the output
// register; the next word is accepted meanwhile, and the sequencer holds at
// its end until the output register frees up. Configuration is taken on any
// cycle.
// ----------------------------------------------------------------------------
`include "sleep_deadline_wakeup_table_unit_defines.svh"

module sleep_deadline_wakeup_table_unit #(
    parameter int PROCESSES = 16,
    parameter int TICK_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sdwt_pkg::CFG_BITS-1:0]    cfg_data,     // [15:0] max_time
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sdwt_pkg::S_DATA_BITS-1:0] s_tdata,      // [3:0] proc_index,
                                                           // [19:4] duration,
                                                           // [35:20] now
    input  logic                             s_tuser,      // [0] func
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sdwt_pkg::M_DATA_BITS-1:0] m_tdata       // [15:0] woken_mask
);

    import sdwt_pkg::*;

    localparam int AddrBits  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int WideBits  = (TICK_BITS > FIELD_BITS) ? TICK_BITS : FIELD_BITS;
    localparam int WideSlots = (PROCESSES > MASK_BITS) ? PROCESSES : MASK_BITS;

    // ------------------------------------------------------------------
    // Control and payload registers
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [TICK_BITS-1:0]   max_time_reg;
    logic [TICK_BITS-1:0]   last_check_reg;
    logic [PROCESSES-1:0]   sleeping_reg;
    logic                   func_reg;
    logic [PROC_BITS-1:0]   proc_reg;
    logic [TICK_BITS-1:0]   dur_reg;
    logic [TICK_BITS-1:0]   now_reg;
    logic [TICK_BITS-1:0]   left_reg;
    logic                   lt_reg;
    logic [TICK_BITS-1:0]   lo_reg;
    logic [TICK_BITS-1:0]   hi_reg;
    logic [AddrBits-1:0]    idx_reg;
    logic [MASK_BITS-1:0]   mask_reg;
    logic                   m_tvalid_reg;
    logic [MASK_BITS-1:0]   m_tdata_reg;

    logic s_fire;
    logic out_free;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Fit 16-bit fields into the tick width (zero-extend or truncate)
    logic [WideBits-1:0] dur_wide, now_wide, cfg_wide, max_rst_wide;
    assign dur_wide     = WideBits'(s_tdata[DUR_LSB +: FIELD_BITS]);
    assign now_wide     = WideBits'(s_tdata[NOW_LSB +: FIELD_BITS]);
    assign cfg_wide     = WideBits'(cfg_data);
    assign max_rst_wide = WideBits'(MAX_TIME_RESET);

    // ------------------------------------------------------------------
    // Shared add/subtract unit: a + b, or a - b with carry as "no borrow"
    // ------------------------------------------------------------------
    logic [TICK_BITS-1:0] alu_a, alu_b;
    logic                 alu_sub;
    logic [TICK_BITS:0]   alu_sum;

    always_comb begin
        alu_a   = max_time_reg;
        alu_b   = now_reg;
        alu_sub = 1'b1;
        unique case (state_reg)
            ST_CMP: begin
                // left < duration shows up as a borrow
                alu_a = left_reg;
                alu_b = dur_reg;
            end
            ST_DEAD: begin
                if (lt_reg) begin
                    alu_a = dur_reg;
                    alu_b = left_reg;
                end else begin
                    alu_a   = now_reg;
                    alu_b   = dur_reg;
                    alu_sub = 1'b0;
                end
            end
            default: begin
                // time left before wrap: max_time - now
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {TICK_BITS{alu_sub}}}
                   + {{TICK_BITS{1'b0}}, alu_sub};

    // ------------------------------------------------------------------
    // Deadline store
    // ------------------------------------------------------------------
    logic [5:0]           proc_wide;
    logic                 slot_ok;
    logic [AddrBits-1:0]  slot_addr;
    logic                 ram_we;
    logic                 ram_re;
    logic [AddrBits-1:0]  ram_raddr;
    logic [TICK_BITS-1:0] ram_rdata;
    logic                 idx_last;

    assign proc_wide = 6'(proc_reg);
    assign slot_ok   = ({26'd0, proc_wide} < 32'(PROCESSES));
    assign slot_addr = proc_wide[AddrBits-1:0];
    assign ram_we    = (state_reg == ST_DEAD) && slot_ok;
    assign idx_last  = (idx_reg == AddrBits'(PROCESSES - 1));
    assign ram_re    = (state_reg == ST_WINDOW) || ((state_reg == ST_SWEEP) && !idx_last);
    assign ram_raddr = (state_reg == ST_SWEEP) ? idx_reg + AddrBits'(1) : '0;

    sdwt_ram #(
        .WIDTH (TICK_BITS),
        .DEPTH (PROCESSES)
    ) u_deadline_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot_addr),
        .wr_data (alu_sum[TICK_BITS-1:0]),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Wake window: wrap handling on the previous check time
    // ------------------------------------------------------------------
    logic                 win_gt;
    logic                 win_at_max;
    logic [TICK_BITS-1:0] win_lo, win_hi;

    assign win_gt     = last_check_reg > now_reg;
    assign win_at_max = last_check_reg == max_time_reg;
    assign win_lo     = (win_at_max && win_gt) ? '0 : last_check_reg;
    assign win_hi     = (win_gt && !win_at_max) ? max_time_reg : now_reg;

    // Sweep compare on the slot whose deadline just came out of the RAM
    logic       hit;
    logic [5:0] idx_wide;

    assign hit      = sleeping_reg[idx_reg] && (ram_rdata >= lo_reg) && (ram_rdata <= hi_reg);
    assign idx_wide = 6'(idx_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == FUNC_CHECK) ? ST_WINDOW : ST_LEFT;
                end
            end
            ST_LEFT:   state_next = ST_CMP;
            ST_CMP:    state_next = ST_DEAD;
            ST_DEAD:   state_next = ST_FINISH;
            ST_WINDOW: state_next = ST_SWEEP;
            ST_SWEEP: begin
                if (idx_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            max_time_reg   <= max_rst_wide[TICK_BITS-1:0];
            last_check_reg <= '0;
            sleeping_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                max_time_reg <= cfg_wide[TICK_BITS-1:0];
            end

            // mark the slot asleep once its deadline is written
            if (ram_we) begin
                sleeping_reg[slot_addr] <= 1'b1;
            end

            if (state_reg == ST_WINDOW) begin
                last_check_reg <= win_hi;
            end

            // drop the flag of every slot woken by the sweep
            if ((state_reg == ST_SWEEP) && hit) begin
                sleeping_reg[idx_reg] <= 1'b0;
            end

            if ((state_reg == ST_FINISH) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg <= s_tuser;
            proc_reg <= s_tdata[PROC_LSB +: PROC_BITS];
            dur_reg  <= dur_wide[TICK_BITS-1:0];
            now_reg  <= now_wide[TICK_BITS-1:0];
            mask_reg <= '0;
        end
        if (state_reg == ST_LEFT) begin
            left_reg <= alu_sum[TICK_BITS-1:0];
        end
        if (state_reg == ST_CMP) begin
            lt_reg <= !alu_sum[TICK_BITS];
        end
        if (state_reg == ST_WINDOW) begin
            lo_reg  <= win_lo;
            hi_reg  <= win_hi;
            idx_reg <= '0;
        end
        if (state_reg == ST_SWEEP) begin
            idx_reg <= idx_reg + AddrBits'(1);
            if (hit && (idx_wide < 6'(MASK_BITS))) begin
                mask_reg[idx_wide[3:0]] <= 1'b1;
            end
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_tdata_reg <= mask_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic [WideSlots-1:0] sleeping_wide;
    logic                 fin_sleep;
    logic                 fin_any;
    logic [MASK_BITS-1:0] woken_still_set;

    assign sleeping_wide   = WideSlots'(sleeping_reg);
    assign fin_sleep       = (state_reg == ST_FINISH) && (func_reg == FUNC_SLEEP);
    assign fin_any         = (state_reg == ST_FINISH);
    assign woken_still_set = mask_reg & sleeping_wide[MASK_BITS-1:0];

    `SDWT_ASSERT_IMP(a_sleep_mask_zero, fin_sleep, mask_reg == '0, "sleep request set mask bits")
    `SDWT_ASSERT_IMP(a_woken_cleared, fin_any, woken_still_set == '0, "woken slot still asleep")
    `SDWT_ASSERT_NXT(a_last_check_hold, state_reg != ST_WINDOW, $stable(last_check_reg), "last check moved")
    `SDWT_ASSERT_NXT(a_accept_starts_work, s_fire, state_reg != ST_IDLE, "accept did not start work")

endmodule

### tb/sv/sleep_deadline_wakeup_table_unit_checker.sv
// ----------------------------------------------------------------------------
// Sleep deadline wakeup table - stream checker
// Watches the config, input and result channels, tracks the sleep table and
// the last check time, and compares each result word with its prediction.
// ----------------------------------------------------------------------------
module sleep_deadline_wakeup_table_unit_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [sdwt_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [sdwt_pkg::S_DATA_BITS-1:0] s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sdwt_pkg::M_DATA_BITS-1:0] m_tdata,
    output int                               error_count,
    output int                               pending_count
);

    import sdwt_pkg::*;

    localparam int SLOTS = 16;

    logic [CFG_BITS-1:0]   max_time = MAX_TIME_RESET;
    logic [FIELD_BITS-1:0] last_check = '0;
    logic                  asleep [SLOTS];
    logic [FIELD_BITS-1:0] wake_at [SLOTS];
    logic [MASK_BITS-1:0]  woken_q [$];
    logic [MASK_BITS-1:0]  want_mask;

    initial begin
        error_count   = 0;
        pending_count = 0;
    end

    // Apply one input word to the table and return the mask it reports.
    function automatic logic [MASK_BITS-1:0] predict_woken_mask(
        input logic                  func,
        input logic [PROC_BITS-1:0]  slot,
        input logic [FIELD_BITS-1:0] dur,
        input logic [FIELD_BITS-1:0] tick
    );
        logic [FIELD_BITS-1:0] left;
        logic [FIELD_BITS-1:0] lo;
        logic [FIELD_BITS-1:0] hi;
        logic [MASK_BITS-1:0]  mask;
        mask = '0;
        if (func == FUNC_SLEEP) begin
            left = max_time - tick;
            if (slot < SLOTS) begin
                asleep[slot]  = 1'b1;
                wake_at[slot] = (left < dur) ? dur - left : tick + dur;
            end
        end else begin
            lo = last_check;
            hi = tick;
            // window that starts at the wrap point restarts from zero
            if (lo == max_time && lo > hi)
                lo = '0;
            // otherwise run the window up to the wrap point only
            if (lo > hi)
                hi = max_time;
            last_check = hi;
            for (int i = 0; i < SLOTS; i++) begin
                if (asleep[i] && wake_at[i] >= lo && wake_at[i] <= hi) begin
                    asleep[i] = 1'b0;
                    mask[i]   = 1'b1;
                end
            end
        end
        return mask;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            max_time   = MAX_TIME_RESET;
            last_check = '0;
            for (int i = 0; i < SLOTS; i++) begin
                asleep[i]  = 1'b0;
                wake_at[i] = '0;
            end
            woken_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                max_time = cfg_data;
            if (m_tvalid && m_tready) begin
                if (woken_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none actual %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want_mask = woken_q.pop_front();
                    if (m_tdata !== want_mask) begin
                        $display("%0t: woken_mask mismatch, expected %h actual %h",
                                 $time, want_mask, m_tdata);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                woken_q.push_back(predict_woken_mask(s_tuser,
                                                     s_tdata[PROC_LSB +: PROC_BITS],
                                                     s_tdata[DUR_LSB +: FIELD_BITS],
                                                     s_tdata[NOW_LSB +: FIELD_BITS]));
        end
        pending_count = woken_q.size();
    end

endmodule

### tb/sv/sleep_deadline_wakeup_table_unit_test.sv
// ----------------------------------------------------------------------------
// Sleep deadline wakeup table - testbench top
// Drives sleep requests and wake checks through several max_time settings
// and pacing modes, including a long result-side hold-off, while a checker
// predicts every woken_mask word.
// ----------------------------------------------------------------------------
module sleep_deadline_wakeup_table_unit_test;
    import sdwt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 24;    // a full sweep plus margin
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_BITS-1:0]    cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata   = '0;   // [3:0] proc_index, [19:4] duration,
                                              // [35:20] now, [39:36] zero
    logic                   s_tuser   = 1'b0; // [0] func
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;          // [15:0] woken_mask

    int error_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_go      = 1'b0;
    int hold_count     = 0;
    int quiet_cycles   = 0;

    // 12-unit period: high then low
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    sleep_deadline_wakeup_table_unit #(
        .PROCESSES (16),
        .TICK_BITS (16)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sleep_deadline_wakeup_table_unit_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Receiver: hold off for a long stretch once asked, else stall at the
    // current rate. Everything changes on the falling edge.
    always @(negedge aclk) begin
        if (hold_go && hold_count < HOLD_CYCLES) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no channel moves a word for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offer one input word, idling first at the sender rate. Entered and left
    // at a falling edge; tvalid stays high on return so back-to-back words
    // never drop it.
    task automatic send_word(input logic func, input logic [PROC_BITS-1:0] slot,
                             input logic [FIELD_BITS-1:0] dur,
                             input logic [FIELD_BITS-1:0] tick);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0000, tick, dur, slot};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop tvalid, wait for every result word, then let the sweep settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write max_time while the block is idle.
    task automatic write_max_time(input logic [CFG_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_pace(input int idle_pct, input int stall_pct);
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        @(negedge aclk);
    endtask

    // Scheduler-like traffic: a tick counter that advances and wraps at
    // maxt, sleeps with short durations and checks at the current tick, with
    // a share of fully random words mixed in.
    task automatic run_random(input int count, input int maxt);
        int sys_tick;
        int pick;
        logic func;
        logic [FIELD_BITS-1:0] dur;
        sys_tick = (maxt > 400) ? maxt - $urandom_range(0, 400) : $urandom_range(0, maxt);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_word(1'($urandom_range(1)), PROC_BITS'($urandom_range(15)),
                          FIELD_BITS'($urandom), FIELD_BITS'($urandom));
            end else begin
                func = (pick < 55) ? FUNC_SLEEP : FUNC_CHECK;
                dur  = ($urandom_range(9) == 0) ? FIELD_BITS'($urandom)
                                                : FIELD_BITS'($urandom_range(0, 64));
                send_word(func, PROC_BITS'($urandom_range(15)), dur,
                          sys_tick[FIELD_BITS-1:0]);
            end
            sys_tick = sys_tick + $urandom_range(0, 16);
            while (sys_tick > maxt)
                sys_tick = sys_tick - (maxt + 1);
        end
    endtask

    initial begin
        int rand_max;

        // Hold reset, then release it on a falling edge.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pass at full range, no idling.
        write_max_time(16'hFFFF);
        set_pace(0, 0);
        send_word(FUNC_SLEEP, 4'd0,  16'd0,     16'd0);     // deadline now
        send_word(FUNC_CHECK, 4'd0,  16'd0,     16'd0);     // wakes slot 0
        send_word(FUNC_SLEEP, 4'd15, 16'hFFFF,  16'hFFFF);  // nothing left, wraps
        send_word(FUNC_SLEEP, 4'd1,  16'd10,    16'd100);
        send_word(FUNC_SLEEP, 4'd1,  16'd20,    16'd100);   // overwrite while asleep
        send_word(FUNC_SLEEP, 4'd2,  16'd100,   16'd65500); // deadline past the wrap
        send_word(FUNC_CHECK, 4'd0,  16'd0,     16'd115);
        send_word(FUNC_CHECK, 4'd0,  16'd0,     16'hFFFF);  // window up to max_time
        send_word(FUNC_CHECK, 4'd0,  16'd0,     16'd5);     // restart from zero
        send_word(FUNC_SLEEP, 4'd3,  16'd3,     16'd65534);
        send_word(FUNC_CHECK, 4'd0,  16'd0,     16'd65534);
        send_word(FUNC_CHECK, 4'd0,  16'd0,     16'd10);    // window clipped at wrap
        send_word(FUNC_CHECK, 4'd0,  16'd0,     16'd10);    // then zero onward
        // Fill every slot and wake them all at once.
        for (int i = 0; i < 16; i++)
            send_word(FUNC_SLEEP, i[PROC_BITS-1:0], 16'd0, 16'd20);
        send_word(FUNC_CHECK, 4'd0, 16'd0, 16'd20);
        drain();

        // Smallest max_time of the run; sender idles two thirds of the time.
        write_max_time(16'd1);
        set_pace(66, 0);
        run_random(100, 1);
        drain();

        // Small max_time so most random ticks sit above it; receiver stalls.
        write_max_time(16'd1000);
        set_pace(0, 66);
        run_random(200, 1000);
        drain();

        // Back to full range; both sides idle a third of the time.
        write_max_time(16'hFFFF);
        set_pace(34, 34);
        run_random(230, 65535);
        drain();

        // Random max_time; hold the receiver off so the block backs up.
        rand_max = $urandom_range(2, 65534);
        write_max_time(rand_max[CFG_BITS-1:0]);
        set_pace(0, 0);
        hold_go <= 1'b1;
        run_random(40, rand_max);
        run_random(200, rand_max);
        drain();

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sdwt_pkg.sv
hw/rtl/sdwt_ram.sv
hw/rtl/sleep_deadline_wakeup_table_unit.sv
tb/sv/sleep_deadline_wakeup_table_unit_checker.sv
tb/sv/sleep_deadline_wakeup_table_unit_test.sv
